### hw/rtl/mpt_pkg.sv
// Shared types and constants for the mouse packet tracker.
package mpt_pkg;

   localparam int unsigned CountWidth = 32;
   localparam int unsigned ScaleWidth = 16;
   localparam int unsigned HoldWidth  = 16;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CsrIdxWidth = 3;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CsrInvertY  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrScaleQ16 = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrCenterX  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrCenterY  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrHoldLen  = 3'd4;

   // Register values after reset
   localparam logic                         ResetInvertY = 1'b0;
   localparam logic [ScaleWidth-1:0]        ResetScale   = 16'd5459;
   localparam logic signed [CountWidth-1:0] ResetCenterX = 32'sd7683;
   localparam logic signed [CountWidth-1:0] ResetCenterY = 32'sd4321;
   localparam logic [HoldWidth-1:0]         ResetHoldLen = 16'd1000;

   // Status byte bits
   localparam int unsigned StatusLeftBit = 0;
   localparam int unsigned StatusXSign   = 4;
   localparam int unsigned StatusYSign   = 5;

   // Scaled magnitude of one axis, sign kept apart until the output stage
   typedef struct packed {
      logic                  neg;
      logic [CountWidth-1:0] mag;
   } scaled_type;

endpackage

### hw/rtl/mouse_packet_tracker.sv
// Mouse packet tracker: poll stream in, scaled position and stretched button out.
//
// One item per poll; one result item per poll, in order. Throughput is one item
// per clock while the result side keeps accepting. The counter update
// (recenter, 9-bit delta, saturating add, button edge and hold countdown)
// happens at acceptance into the counter stage, the next stage does the 32x16
// sign-magnitude multiply, and the last stage restores the sign into the
// output register. Each stage moves forward whenever the one after it is
// empty or draining, so bubbles are squeezed out and new items are taken while
// a finished result waits. The position counters are the first stage's
// payload, so they change only when an item is accepted. Configuration writes
// are always accepted and take effect on the next item; write them only while
// the pipeline is empty.
module mouse_packet_tracker (
   input  logic        clock,
   input  logic        reset,
   // Input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] packet_valid, [1] recenter, [9:2] status_byte, [17:10] dx_byte,
   // [25:18] dy_byte, [31:26] zero
   input  logic [31:0] req_tdata,
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] pos_x, [63:32] pos_y, [64] button_held, [71:65] zero
   output logic [71:0] rsp_tdata,
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mpt_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [31:0] csr_data
);

   localparam int unsigned CW = mpt_pkg::CountWidth;
   localparam int unsigned HW = mpt_pkg::HoldWidth;
   localparam int unsigned SumWidth = CW + 2;

   // Clamp limits of a position counter, widened to the sum
   localparam logic signed [SumWidth-1:0] SumMax = SumWidth'(32'sh7FFF_FFFF);
   localparam logic signed [SumWidth-1:0] SumMin = SumWidth'(32'sh8000_0000);

   // Configuration registers
   logic                         flip_y_ff;
   logic [mpt_pkg::ScaleWidth-1:0] scale_ff;
   logic signed [CW-1:0]         center_x_ff;
   logic signed [CW-1:0]         center_y_ff;
   logic [HW-1:0]                hold_len_ff;

   // Tracker state, also the payload of the first stage
   logic signed [CW-1:0] count_x_ff, count_x_in;
   logic signed [CW-1:0] count_y_ff, count_y_in;
   logic                 was_down_ff, was_down_in;
   logic [HW-1:0]        hold_left_ff, hold_left_in;
   logic                 s1_held_ff, s1_held_in;
   logic                 s1_v_ff;

   // Second stage
   mpt_pkg::scaled_type  s2_x_ff, s2_y_ff, sc_x, sc_y;
   logic                 s2_held_ff;
   logic                 s2_v_ff;

   // Output register
   logic signed [CW-1:0] pos_x_ff, pos_y_ff;
   logic                 held_ff;
   logic                 out_v_ff;

   // Input fields
   logic                 in_pkt, in_recenter;
   logic [7:0]           in_status, in_dx, in_dy;

   logic                 req_fire, out_free, s2_free, s1_free;

   logic signed [CW-1:0]       base_x, base_y;
   logic signed [9:0]          dx_delta, dy_delta;
   logic signed [SumWidth-1:0] sum_x, sum_y;
   logic [HW-1:0]              hold_loaded;

   assign in_pkt      = req_tdata[0];
   assign in_recenter = req_tdata[1];
   assign in_status   = req_tdata[9:2];
   assign in_dx       = req_tdata[17:10];
   assign in_dy       = req_tdata[25:18];

   // Handshakes: a stage takes a new item when empty or when it hands its own on
   assign out_free   = !out_v_ff || rsp_tready;
   assign s2_free    = !s2_v_ff || out_free;
   assign s1_free    = !s1_v_ff || s2_free;
   assign req_tready = s1_free;
   assign req_fire   = req_tvalid && s1_free;
   assign csr_ready  = 1'b1;

   // Counter update for the item being accepted
   always_comb begin
      base_x   = in_recenter ? center_x_ff : count_x_ff;
      base_y   = in_recenter ? center_y_ff : count_y_ff;
      dx_delta = '0;
      dy_delta = '0;
      if (in_pkt) begin
         dx_delta = {{1{in_status[mpt_pkg::StatusXSign]}},
                     in_status[mpt_pkg::StatusXSign], in_dx};
         dy_delta = {{1{in_status[mpt_pkg::StatusYSign]}},
                     in_status[mpt_pkg::StatusYSign], in_dy};
      end
      // Flip vertical movement before accumulation; 10 bits hold +256
      if (flip_y_ff) begin
         dy_delta = -dy_delta;
      end
      sum_x = SumWidth'(base_x) + SumWidth'(dx_delta);
      sum_y = SumWidth'(base_y) + SumWidth'(dy_delta);

      // Clamp to the 32-bit signed range
      if (sum_x > SumMax) begin
         count_x_in = 32'sh7FFF_FFFF;
      end else if (sum_x < SumMin) begin
         count_x_in = 32'sh8000_0000;
      end else begin
         count_x_in = sum_x[CW-1:0];
      end
      if (sum_y > SumMax) begin
         count_y_in = 32'sh7FFF_FFFF;
      end else if (sum_y < SumMin) begin
         count_y_in = 32'sh8000_0000;
      end else begin
         count_y_in = sum_y[CW-1:0];
      end

      // Left button: load the hold counter on a press edge, then count down
      hold_loaded = hold_left_ff;
      was_down_in = was_down_ff;
      if (in_pkt) begin
         if (in_status[mpt_pkg::StatusLeftBit] && !was_down_ff) begin
            hold_loaded = hold_len_ff;
         end
         was_down_in = in_status[mpt_pkg::StatusLeftBit];
      end
      s1_held_in   = (hold_loaded != '0);
      hold_left_in = s1_held_in ? (hold_loaded - 1'b1) : hold_loaded;
   end

   mpt_scale u_scale_x (
      .count  (count_x_ff),
      .scale  (scale_ff),
      .result (sc_x)
   );

   mpt_scale u_scale_y (
      .count  (count_y_ff),
      .scale  (scale_ff),
      .result (sc_y)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flip_y_ff   <= mpt_pkg::ResetInvertY;
         scale_ff    <= mpt_pkg::ResetScale;
         center_x_ff <= mpt_pkg::ResetCenterX;
         center_y_ff <= mpt_pkg::ResetCenterY;
         hold_len_ff <= mpt_pkg::ResetHoldLen;
      end else if (csr_valid) begin
         unique case (csr_index)
            mpt_pkg::CsrInvertY:  flip_y_ff   <= csr_data[0];
            mpt_pkg::CsrScaleQ16: scale_ff    <= csr_data[mpt_pkg::ScaleWidth-1:0];
            mpt_pkg::CsrCenterX:  center_x_ff <= csr_data;
            mpt_pkg::CsrCenterY:  center_y_ff <= csr_data;
            mpt_pkg::CsrHoldLen:  hold_len_ff <= csr_data[HW-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Tracker state and first stage
   always_ff @(posedge clock) begin
      if (reset) begin
         count_x_ff   <= '0;
         count_y_ff   <= '0;
         was_down_ff  <= 1'b0;
         hold_left_ff <= '0;
         s1_v_ff      <= 1'b0;
      end else begin
         if (req_fire) begin
            count_x_ff   <= count_x_in;
            count_y_ff   <= count_y_in;
            was_down_ff  <= was_down_in;
            hold_left_ff <= hold_left_in;
         end
         if (s1_free) begin
            s1_v_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_held_ff <= s1_held_in;
      end
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_free) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_v_ff) begin
         s2_x_ff    <= sc_x;
         s2_y_ff    <= sc_y;
         s2_held_ff <= s1_held_ff;
      end
   end

   // Output register: restore the sign, which truncates toward zero
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_v_ff) begin
         pos_x_ff <= s2_x_ff.neg ? -s2_x_ff.mag : s2_x_ff.mag;
         pos_y_ff <= s2_y_ff.neg ? -s2_y_ff.mag : s2_y_ff.mag;
         held_ff  <= s2_held_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, held_ff, pos_y_ff, pos_x_ff};

   // Counters move only when an item is accepted
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_x_ff) && $stable(count_y_ff))
      else $error("position counters changed without an accepted item");

   // Hold counter only changes on an accepted item
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(hold_left_ff))
      else $error("hold counter changed without an accepted item");

   // An item with neither packet nor recenter leaves the counters alone
   a_no_move: assert property (@(posedge clock) disable iff (reset)
      req_fire && !in_pkt && !in_recenter |=> $stable(count_x_ff) && $stable(count_y_ff))
      else $error("counters moved on an empty poll");

   // A blocked first stage keeps its item
   a_s1_keep: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && !s2_free |=> s1_v_ff)
      else $error("first stage lost an item while stalled");

endmodule

### hw/rtl/mpt_scale.sv
// Sign-magnitude scaling of one position counter by a Q0.16 fraction.
module mpt_scale (
   input  logic signed [mpt_pkg::CountWidth-1:0] count,
   input  logic        [mpt_pkg::ScaleWidth-1:0] scale,
   output mpt_pkg::scaled_type                   result
);

   logic [mpt_pkg::CountWidth-1:0]                      mag;
   logic [mpt_pkg::CountWidth+mpt_pkg::ScaleWidth-1:0] prod;

   // Magnitude of the most negative count is 2^31, still fits unsigned
   assign mag  = count[mpt_pkg::CountWidth-1] ? (~count + 1'b1) : count;
   assign prod = mag * scale;

   always_comb begin
      result.neg = count[mpt_pkg::CountWidth-1];
      result.mag = prod[mpt_pkg::CountWidth+mpt_pkg::ScaleWidth-1:mpt_pkg::ScaleWidth];
   end

endmodule
